>>> hdl/fdoi_pkg.sv
// Shared types, constants and helper functions for the face DOF orientation index core.
// Used by every module under hdl/. It depends on nothing else.

package fdoi_pkg;

   // Field widths
   localparam int FACE_W = 3;
   localparam int ORI_W  = 3;
   localparam int DOF_W  = 8;
   localparam int N_W    = 5;
   localparam int DIM_W  = 2;
   localparam int ERR_W  = 2;

   // Largest edge DOF count the mapping honors; larger counts saturate to it
   localparam int MAX_DOFS_PER_EDGE = 16;

   // Restoring divider layout: quotient bits retired per stage, and stage count
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = DOF_W / DIV_BITS_PER_STAGE;

   // Dimension codes; any other value maps as 1D
   localparam logic [DIM_W-1:0] DIM_PLANAR  = 2'd2;
   localparam logic [DIM_W-1:0] DIM_SPATIAL = 2'd3;

   // Register indexes of the configuration port
   localparam logic CSR_DIMENSION     = 1'b0;
   localparam logic CSR_DOFS_PER_EDGE = 1'b1;

   // Face numbers with their own handling
   localparam logic [FACE_W-1:0] FACE_LAST_PLANAR_KEEP = 3'd1;
   localparam logic [FACE_W-1:0] FACE_FIRST_INVALID    = 3'd6;
   localparam logic [FACE_W-1:0] FACE_ZERO             = 3'd0;
   localparam logic [FACE_W-1:0] FACE_THREE            = 3'd3;
   localparam logic [FACE_W-1:0] FACE_FOUR             = 3'd4;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FACE  = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

   // Face groups that share one orientation table
   typedef enum logic [1:0] {
      GRP_FACE0  = 2'd0,
      GRP_SIDE   = 2'd1,
      GRP_FACE34 = 2'd2
   } grp_type;

   // Coordinate selectors: a, b, and their complements n-1-a, n-1-b
   typedef enum logic [1:0] {
      SEL_A  = 2'd0,
      SEL_B  = 2'd1,
      SEL_AC = 2'd2,
      SEL_BC = 2'd3
   } sel_type;

   typedef struct packed {
      sel_type k1;
      sel_type k2;
   } sel_pair_type;

   // Item carried down the pipeline
   typedef struct packed {
      err_type          err;      // error code, final from the front stage on
      logic             use_3d;   // result comes from the spatial mapping
      logic [DOF_W-1:0] direct;   // result for 1D/2D and for errors
      grp_type          grp;
      logic [ORI_W-1:0] ori;
      logic [DOF_W-1:0] quo;      // dividend bits shift out, quotient bits shift in
      logic [N_W-1:0]   rem;      // partial remainder
   } item_type;

   localparam sel_pair_type SEL_TAB_FACE0 [8] = '{
      '{SEL_A,  SEL_BC}, '{SEL_BC, SEL_A }, '{SEL_BC, SEL_AC}, '{SEL_AC, SEL_BC},
      '{SEL_AC, SEL_B }, '{SEL_B,  SEL_AC}, '{SEL_B,  SEL_A }, '{SEL_A,  SEL_B }
   };
   localparam sel_pair_type SEL_TAB_SIDE [8] = '{
      '{SEL_A,  SEL_B }, '{SEL_B,  SEL_A }, '{SEL_B,  SEL_AC}, '{SEL_AC, SEL_B },
      '{SEL_AC, SEL_BC}, '{SEL_BC, SEL_AC}, '{SEL_BC, SEL_A }, '{SEL_A,  SEL_BC}
   };
   localparam sel_pair_type SEL_TAB_FACE34 [8] = '{
      '{SEL_AC, SEL_B }, '{SEL_B,  SEL_AC}, '{SEL_B,  SEL_A }, '{SEL_A,  SEL_B },
      '{SEL_A,  SEL_BC}, '{SEL_BC, SEL_A }, '{SEL_BC, SEL_AC}, '{SEL_AC, SEL_BC}
   };

   // Look up the selector pair for a face group and orientation
   function automatic sel_pair_type sel_lookup(grp_type grp, logic [ORI_W-1:0] ori);
      sel_pair_type pair;
      case (grp)
         GRP_SIDE:   pair = SEL_TAB_SIDE[ori];
         GRP_FACE34: pair = SEL_TAB_FACE34[ori];
         default:    pair = SEL_TAB_FACE0[ori];
      endcase
      return pair;
   endfunction

   // Pick one coordinate by selector
   function automatic logic [N_W-1:0] pick(sel_type sel, logic [N_W-1:0] a,
                                           logic [N_W-1:0] b, logic [N_W-1:0] n);
      logic [N_W-1:0] val;
      case (sel)
         SEL_A:   val = a;
         SEL_B:   val = b;
         SEL_AC:  val = n - N_W'(1) - a;
         default: val = n - N_W'(1) - b;
      endcase
      return val;
   endfunction

endpackage

>>> hdl/face_dof_orientation_index_core.sv
// Face DOF orientation index core: maps a DOF index within an element face to its index
// after the face is reoriented. It takes one request per clock while the response side is
// ready and returns one response per request, in order, through one decode stage, four
// divider stages that each retire two quotient bits of d / n, and one stage that applies
// the orientation and forms k1 + n*k2. Every stage holds its own valid bit, so
// bubbles close up under backpressure. Configuration registers (index 0 dimension, index 1
// DOFs per edge) are written through the csr_ port, which is always ready, and must only be
// written while no request is in flight. Errors return local_index zero with error code
// 1 (face 6 or 7 in 3D) or 2 (index out of range).
// Depends on fdoi_pkg, fdoi_front, fdoi_div_stage and fdoi_back.

module face_dof_orientation_index_core
   import fdoi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // face_id[2:0], orientation[5:3], face_dof[13:6], zero pad
   // Responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // local_index[7:0]
   output logic [1:0]  rsp_tuser,   // error_code[1:0]
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);

   logic [DIM_W-1:0] dimension_ff;
   logic [N_W-1:0]   dofs_ff;
   logic [N_W-1:0]   n_eff;

   logic     stage_valid [DIV_STAGES+1];
   logic     stage_ready [DIV_STAGES+1];
   item_type stage_item  [DIV_STAGES+1];

   // Hold configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_SPATIAL;
         dofs_ff      <= N_W'(2);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIMENSION:     dimension_ff <= csr_data[DIM_W-1:0];
            CSR_DOFS_PER_EDGE: dofs_ff      <= csr_data;
            default:           dofs_ff      <= dofs_ff;
         endcase
      end
   end

   // Clamp n to the range 1 .. MAX_DOFS_PER_EDGE
   always_comb begin
      if (dofs_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(dofs_ff) > 32'(MAX_DOFS_PER_EDGE)) begin
         n_eff = N_W'(MAX_DOFS_PER_EDGE);
      end else begin
         n_eff = dofs_ff;
      end
   end

   fdoi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .dimension   (dimension_ff),
      .n           (n_eff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .face_id     (req_tdata[2:0]),
      .orientation (req_tdata[5:3]),
      .face_dof    (req_tdata[13:6]),
      .out_valid   (stage_valid[0]),
      .out_ready   (stage_ready[0]),
      .out_item    (stage_item[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      fdoi_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .n         (n_eff),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_item   (stage_item[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_item  (stage_item[s+1])
      );
   end

   fdoi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .n           (n_eff),
      .in_valid    (stage_valid[DIV_STAGES]),
      .in_ready    (stage_ready[DIV_STAGES]),
      .in_item     (stage_item[DIV_STAGES]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .local_index (rsp_tdata),
      .error_code  (rsp_tuser)
   );

   // An error response always carries index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ERR_NONE) |-> rsp_tdata == '0)
      else $error("error response with nonzero local_index");

   // No response code beyond the defined ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ERR_NONE) || (rsp_tuser == ERR_FACE)
                     || (rsp_tuser == ERR_RANGE))
      else $error("undefined error_code on response");

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

>>> hdl/fdoi_front.sv
// Front stage: decodes the request, checks face and index range, settles 1D/2D results.
// Depends on fdoi_pkg.

module fdoi_front
   import fdoi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DIM_W-1:0]  dimension,
   input  logic [N_W-1:0]    n,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [FACE_W-1:0] face_id,
   input  logic [ORI_W-1:0]  orientation,
   input  logic [DOF_W-1:0]  face_dof,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;
   logic [2*N_W-1:0] n_sq;

   assign n_sq = (2*N_W)'(n) * (2*N_W)'(n);

   // Decode the request into a pipeline item
   always_comb begin
      item_in        = '0;
      item_in.err    = ERR_NONE;
      item_in.ori    = orientation;
      item_in.quo    = face_dof;
      item_in.rem    = '0;
      case (face_id)
         FACE_ZERO:             item_in.grp = GRP_FACE0;
         FACE_THREE, FACE_FOUR: item_in.grp = GRP_FACE34;
         default:               item_in.grp = GRP_SIDE;
      endcase
      case (dimension)
         DIM_PLANAR: begin
            if ({3'b0, n} <= face_dof) begin
               item_in.err = ERR_RANGE;
            end else if (face_id <= FACE_LAST_PLANAR_KEEP) begin
               item_in.direct = face_dof;
            end else begin
               item_in.direct = DOF_W'(n) - DOF_W'(1) - face_dof;
            end
         end
         DIM_SPATIAL: begin
            if (face_id >= FACE_FIRST_INVALID) begin
               item_in.err = ERR_FACE;
            end else if (n_sq <= (2*N_W)'(face_dof)) begin
               item_in.err = ERR_RANGE;
            end else begin
               item_in.use_3d = 1'b1;
            end
         end
         default: begin
            item_in.direct = face_dof;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance when the next stage takes the held item or none is held
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> hdl/fdoi_div_stage.sv
// One stage of the pipelined restoring divider that splits the DOF index by n.
// Depends on fdoi_pkg.

module fdoi_div_stage
   import fdoi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [N_W-1:0] n,
   input  logic           in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output item_type       out_item
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   // Retire DIV_BITS_PER_STAGE quotient bits: shift, trial subtract, restore
   always_comb begin
      logic [N_W:0] trial;
      item_in = in_item;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         trial       = {item_in.rem, item_in.quo[DOF_W-1]};
         item_in.quo = {item_in.quo[DOF_W-2:0], 1'b0};
         if (trial >= {1'b0, n}) begin
            trial          = trial - {1'b0, n};
            item_in.quo[0] = 1'b1;
         end
         item_in.rem = trial[N_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> hdl/fdoi_back.sv
// Back stage: applies the orientation permutation and forms k1 + n*k2, output register.
// Depends on fdoi_pkg.

module fdoi_back
   import fdoi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [N_W-1:0]    n,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DOF_W-1:0]  local_index,
   output logic [ERR_W-1:0]  error_code
);

   logic             valid_ff;
   logic [DOF_W-1:0] index_ff;
   logic [DOF_W-1:0] index_in;
   logic [ERR_W-1:0] err_ff;
   sel_pair_type     pair;
   logic [N_W-1:0]   k1;
   logic [N_W-1:0]   k2;
   logic [2*N_W-1:0] full;

   // Remainder is a, quotient is b
   always_comb begin
      pair = sel_lookup(in_item.grp, in_item.ori);
      k1   = pick(pair.k1, in_item.rem, in_item.quo[N_W-1:0], n);
      k2   = pick(pair.k2, in_item.rem, in_item.quo[N_W-1:0], n);
      full = (2*N_W)'(n) * (2*N_W)'(k2) + (2*N_W)'(k1);
      index_in = in_item.use_3d ? full[DOF_W-1:0] : in_item.direct;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         index_ff <= index_in;
         err_ff   <= in_item.err;
      end
   end

   assign out_valid   = valid_ff;
   assign local_index = index_ff;
   assign error_code  = err_ff;

endmodule

>>> bench/tb.sv
// Testbench for face_dof_orientation_index_core: directed rows, then random requests per
// configuration, each response checked against a typed-in answer or an in-bench orientation predictor.
// Depends on hdl/fdoi_pkg.sv and hdl/face_dof_orientation_index_core.sv.
`timescale 1ns / 100ps

module tb
   import fdoi_pkg::*;
();

   localparam int RAND_PHASES      = 10;
   localparam int RAND_PER_PHASE   = 93;
   localparam int DRAIN_SLACK      = 12;      // pipeline depth plus margin
   localparam int LONG_HOLD_AT     = 400;     // requests accepted before the long stall
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int MAX_REPORTS      = 10;
   localparam int DIRECTED_ROWS    = 24;

   // Expected response: index after reorientation and error code
   typedef struct packed {
      logic [DOF_W-1:0] idx;
      err_type          err;
   } placed_dof_type;

   // Directed row: configuration, request, and an optional typed-in answer
   typedef struct packed {
      logic [DIM_W-1:0]  dim;
      logic [N_W-1:0]    dofs;
      logic [FACE_W-1:0] face;
      logic [ORI_W-1:0]  ori;
      logic [DOF_W-1:0]  dof;
      bit                typed;
      logic [DOF_W-1:0]  idx;
      err_type           err;
   } dir_row_type;

   // Coordinate selectors (k1, k2) per face group and orientation
   localparam sel_type ORIENT_SEL [3][8][2] = '{
      '{ '{SEL_A,  SEL_BC}, '{SEL_BC, SEL_A }, '{SEL_BC, SEL_AC}, '{SEL_AC, SEL_BC},
         '{SEL_AC, SEL_B }, '{SEL_B,  SEL_AC}, '{SEL_B,  SEL_A }, '{SEL_A,  SEL_B } },
      '{ '{SEL_A,  SEL_B }, '{SEL_B,  SEL_A }, '{SEL_B,  SEL_AC}, '{SEL_AC, SEL_B },
         '{SEL_AC, SEL_BC}, '{SEL_BC, SEL_AC}, '{SEL_BC, SEL_A }, '{SEL_A,  SEL_BC} },
      '{ '{SEL_AC, SEL_B }, '{SEL_B,  SEL_AC}, '{SEL_B,  SEL_A }, '{SEL_A,  SEL_B },
         '{SEL_A,  SEL_BC}, '{SEL_BC, SEL_A }, '{SEL_BC, SEL_AC}, '{SEL_AC, SEL_BC} }
   };

   localparam dir_row_type DIRECTED [DIRECTED_ROWS] = '{
      // reset configuration: 3D, two DOFs per edge
      '{2'd3, 5'd2,  3'd6, 3'd0, 8'd0,   1'b1, 8'd0,   ERR_FACE },
      '{2'd3, 5'd2,  3'd7, 3'd7, 8'd255, 1'b1, 8'd0,   ERR_FACE },
      '{2'd3, 5'd2,  3'd0, 3'd0, 8'd4,   1'b1, 8'd0,   ERR_RANGE},
      '{2'd3, 5'd2,  3'd1, 3'd0, 8'd3,   1'b1, 8'd3,   ERR_NONE },
      '{2'd3, 5'd2,  3'd0, 3'd7, 8'd2,   1'b1, 8'd2,   ERR_NONE },
      '{2'd3, 5'd2,  3'd0, 3'd1, 8'd1,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd2, 3'd2, 8'd2,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd3, 3'd3, 8'd1,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd4, 3'd4, 8'd2,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd5, 3'd5, 8'd1,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd3, 3'd6, 8'd3,   1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd2,  3'd0, 3'd6, 8'd0,   1'b0, 8'd0,   ERR_NONE },
      // largest edge, full index range
      '{2'd3, 5'd16, 3'd0, 3'd0, 8'd255, 1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd16, 3'd3, 3'd7, 8'd255, 1'b0, 8'd0,   ERR_NONE },
      '{2'd3, 5'd16, 3'd2, 3'd5, 8'd0,   1'b0, 8'd0,   ERR_NONE },
      // edge count above the maximum saturates
      '{2'd3, 5'd31, 3'd1, 3'd2, 8'd200, 1'b0, 8'd0,   ERR_NONE },
      // edge count zero acts as one
      '{2'd3, 5'd0,  3'd0, 3'd0, 8'd0,   1'b1, 8'd0,   ERR_NONE },
      '{2'd3, 5'd0,  3'd2, 3'd3, 8'd1,   1'b1, 8'd0,   ERR_RANGE},
      // planar: keep on faces 0-1, reverse elsewhere, range check on every face
      '{2'd2, 5'd4,  3'd0, 3'd0, 8'd3,   1'b1, 8'd3,   ERR_NONE },
      '{2'd2, 5'd4,  3'd5, 3'd7, 8'd0,   1'b1, 8'd3,   ERR_NONE },
      '{2'd2, 5'd4,  3'd7, 3'd0, 8'd4,   1'b1, 8'd0,   ERR_RANGE},
      // 1D and dimension zero pass the index through, then planar with edge count zero
      '{2'd1, 5'd2,  3'd7, 3'd7, 8'd255, 1'b1, 8'd255, ERR_NONE },
      '{2'd0, 5'd16, 3'd6, 3'd3, 8'd129, 1'b1, 8'd129, ERR_NONE },
      '{2'd2, 5'd0,  3'd1, 3'd0, 8'd0,   1'b1, 8'd0,   ERR_NONE }
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // face_id[2:0], orientation[5:3], face_dof[13:6], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // local_index[7:0]
   logic [1:0]  rsp_tuser;         // error_code[1:0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [4:0]  csr_data   = '0;

   // Predictor copy of the configuration registers
   logic [DIM_W-1:0] cfg_dim       = 2'd3;
   logic [N_W-1:0]   cfg_edge_dofs = 5'd2;

   placed_dof_type pending_q [$];
   int             req_count      = 0;
   int             mismatch_count = 0;
   logic [15:0]    sim_cycles     = '0;
   int             rsp_hold       = 0;
   bit             long_hold_done = 1'b0;

   face_dof_orientation_index_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      sim_cycles <= sim_cycles + 16'd1;
   end

   // Edge DOF count after clamping zero to one and saturating at the maximum
   function automatic int edge_dofs_eff();
      int n;
      n = cfg_edge_dofs;
      if (n == 0) n = 1;
      if (n > MAX_DOFS_PER_EDGE) n = MAX_DOFS_PER_EDGE;
      return n;
   endfunction

   function automatic int coord(sel_type s, int a, int b, int n);
      case (s)
         SEL_A:   return a;
         SEL_B:   return b;
         SEL_AC:  return n - 1 - a;
         default: return n - 1 - b;
      endcase
   endfunction

   // Reoriented index and error code for one request under the current configuration
   function automatic placed_dof_type reorient_dof(logic [FACE_W-1:0] face,
                                                   logic [ORI_W-1:0] ori,
                                                   logic [DOF_W-1:0] dof);
      placed_dof_type r;
      int             n, a, b, k1, k2;
      grp_type        grp;
      r.idx = '0;
      r.err = ERR_NONE;
      n = edge_dofs_eff();
      if (cfg_dim == DIM_PLANAR) begin
         if (int'(dof) >= n) r.err = ERR_RANGE;
         else if (face <= FACE_LAST_PLANAR_KEEP) r.idx = dof;
         else r.idx = DOF_W'(n - 1 - int'(dof));
      end else if (cfg_dim == DIM_SPATIAL) begin
         if (face >= FACE_FIRST_INVALID) begin
            r.err = ERR_FACE;
         end else if (int'(dof) >= n * n) begin
            r.err = ERR_RANGE;
         end else begin
            if (face == FACE_ZERO) grp = GRP_FACE0;
            else if (face == FACE_THREE || face == FACE_FOUR) grp = GRP_FACE34;
            else grp = GRP_SIDE;
            a = int'(dof) % n;
            b = int'(dof) / n;
            k1 = coord(ORIENT_SEL[grp][ori][0], a, b, n);
            k2 = coord(ORIENT_SEL[grp][ori][1], a, b, n);
            r.idx = DOF_W'(k1 + n * k2);
         end
      end else begin
         r.idx = dof;
      end
      return r;
   endfunction

   // Offer one request, hold it until accepted, then queue its expected response
   task automatic send_request(input logic [FACE_W-1:0] face, input logic [ORI_W-1:0] ori,
                               input logic [DOF_W-1:0] dof, input bit typed,
                               input placed_dof_type typed_rsp);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, dof, ori, face};
      do @(posedge clock); while (req_tready !== 1'b1);
      req_count++;
      pending_q.push_back(typed ? typed_rsp : reorient_dof(face, ori, dof));
   endtask

   // Drop valid for a random gap: mostly none or short, a few long
   task automatic sender_gap(input bit calm);
      int roll, gap;
      roll = $urandom_range(99);
      if (calm || roll < 55) gap = 0;
      else if (roll < 93) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every pending response, then let the pipeline empty
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Write dimension then edge DOF count; dimension upper data bits carry junk
   task automatic write_config(input logic [DIM_W-1:0] dim, input logic [N_W-1:0] dofs);
      logic [N_W-1:0] dim_word;
      dim_word = {3'($urandom_range(7)), dim};
      csr_valid <= 1'b1;
      csr_index <= CSR_DIMENSION;
      csr_data  <= dim_word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_dim = dim_word[DIM_W-1:0];
      csr_index <= CSR_DOFS_PER_EDGE;
      csr_data  <= dofs;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_edge_dofs = dofs;
      csr_valid <= 1'b0;
   endtask

   // Response side pacing: random stalls, calm stretches, and one long hold-off
   always @(posedge clock) begin : rsp_pacing
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (!long_hold_done && req_count >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         rsp_tready     <= 1'b0;
         rsp_hold       <= LONG_HOLD_CYCLES;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         roll = $urandom_range(99);
         if (sim_cycles[9:8] != 2'b00 && roll < 20) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= (roll < 2) ? $urandom_range(40, 10) : $urandom_range(3, 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin : rsp_check
      placed_dof_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_q.size() == 0) begin
            note_mismatch("unexpected response, local_index", -1, int'(rsp_tdata));
         end else begin
            want = pending_q.pop_front();
            if (rsp_tdata !== want.idx)
               note_mismatch("local_index", int'(want.idx), int'(rsp_tdata));
            if (rsp_tuser !== want.err)
               note_mismatch("error_code", int'(want.err), int'(rsp_tuser));
         end
      end
   end

   initial begin : stimulus
      dir_row_type       row;
      placed_dof_type    typed_rsp;
      logic [DIM_W-1:0]  dim;
      logic [N_W-1:0]    dofs;
      logic [FACE_W-1:0] face;
      logic [ORI_W-1:0]  ori;
      logic [DOF_W-1:0]  dof;
      bit                calm;
      int                roll, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; reconfigure between rows only when idle
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         row = DIRECTED[k];
         if (row.dim != cfg_dim || row.dofs != cfg_edge_dofs) begin
            drain_requests();
            write_config(row.dim, row.dofs);
         end
         typed_rsp.idx = row.idx;
         typed_rsp.err = row.err;
         send_request(row.face, row.ori, row.dof, row.typed, typed_rsp);
         sender_gap(1'b0);
      end

      // Random phases: extremes of both registers first, then random settings
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: begin dim = DIM_SPATIAL; dofs = 5'd16; end
            1: begin dim = DIM_SPATIAL; dofs = 5'd1;  end
            2: begin dim = DIM_SPATIAL; dofs = 5'd31; end
            3: begin dim = DIM_SPATIAL; dofs = 5'd0;  end
            4: begin dim = DIM_PLANAR;  dofs = 5'd16; end
            5: begin dim = DIM_PLANAR;  dofs = 5'd1;  end
            6: begin dim = 2'd1;        dofs = 5'd9;  end
            7: begin dim = 2'd0;        dofs = 5'd3;  end
            default: begin
               dim  = DIM_W'($urandom_range(3));
               dofs = N_W'($urandom_range(31));
            end
         endcase
         drain_requests();
         write_config(dim, dofs);
         calm = ($urandom_range(3) == 0);
         n = edge_dofs_eff();
         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            roll = $urandom_range(99);
            face = FACE_W'($urandom_range(7));
            ori  = ORI_W'($urandom_range(7));
            dof  = DOF_W'($urandom_range(255));
            // most requests are well formed; the rest stay fully random
            if (roll >= 12) begin
               if (cfg_dim == DIM_SPATIAL) begin
                  face = FACE_W'($urandom_range(5));
                  if (roll >= 20) dof = DOF_W'($urandom_range(n * n - 1));
               end else if (cfg_dim == DIM_PLANAR && roll >= 20) begin
                  dof = DOF_W'($urandom_range(n - 1));
               end
            end
            typed_rsp = '0;
            send_request(face, ori, dof, 1'b0, typed_rsp);
            sender_gap(calm);
         end
      end

      drain_requests();
      if (mismatch_count == 0 && pending_q.size() == 0) begin
         $display("face_dof_orientation_index_core test passed");
      end else begin
         $display("face_dof_orientation_index_core test failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run
   initial begin : run_limit
      #5000000;
      $display("face_dof_orientation_index_core test failed");
      $finish;
   end

endmodule

>>> face_dof_orientation_index_core.f
hdl/fdoi_pkg.sv
hdl/fdoi_front.sv
hdl/fdoi_div_stage.sv
hdl/fdoi_back.sv
hdl/face_dof_orientation_index_core.sv
bench/tb.sv
